// ----- rtl/dop_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dop_pkg
// Shared types, sizes and helpers for the DSD-over-PCM packer.
// ----------------------------------------------------------------------------
package dop_pkg;

	localparam int MAX_CHANNELS    = 8;
	localparam int MAX_BLOCK_BYTES = 4096;

	localparam int CH_W   = $clog2(MAX_CHANNELS);
	localparam int POS_W  = CH_W + 1;
	localparam int OFF_W  = $clog2(MAX_BLOCK_BYTES);
	localparam int PAIR_W = OFF_W - 1;
	localparam int ADDR_W = CH_W + PAIR_W;
	localparam int CNT_W  = 4;
	localparam int BLK_W  = 13;

	localparam logic [7:0] MARKER_ODD  = 8'h05;
	localparam logic [7:0] MARKER_EVEN = 8'hFA;

	localparam logic [1:0] CMD_HOLD  = 2'd0;
	localparam logic [1:0] CMD_PAIR  = 2'd1;
	localparam logic [1:0] CMD_STORE = 2'd2;
	localparam logic [1:0] CMD_BURST = 2'd3;

	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [2:0] REG_PLANAR_LAYOUT = 3'd1;
	localparam logic [2:0] REG_BLOCK_BYTES   = 3'd2;
	localparam logic [2:0] REG_KEEP_ORDER    = 3'd3;
	localparam logic [2:0] REG_WIDEN_TO_32   = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0] channel_count;
		logic             planar_layout;
		logic [BLK_W-1:0] block_bytes;
		logic             keep_order;
		logic             widen_to_32;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        data;
		logic [CH_W-1:0]   chan;
		logic [PAIR_W-1:0] pair;
		logic              lane;
		logic              last;
		logic [CH_W-1:0]   last_chan;
	} cmd_t;

	function automatic logic [7:0] flip_bits(input logic [7:0] v);
		logic [7:0] x;
		x = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
		x = ((x & 8'hCC) >> 2) | ((x & 8'h33) << 2);
		x = ((x & 8'hAA) >> 1) | ((x & 8'h55) << 1);
		return x;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/dop_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dop_front
// Accepts raw bytes, tracks the frame or block position and issues commands.
// ----------------------------------------------------------------------------
module dop_front import dop_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       restart,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] data_byte,
	output cmd_t            cmd,
	output logic            cmd_valid,
	input  wire logic       cmd_ready
);

	logic [POS_W-1:0] pos_q;
	logic [CH_W-1:0]  chan_q;
	logic [OFF_W-1:0] off_q;

	logic [POS_W-1:0] ch;
	logic [CH_W-1:0]  last_chan;
	logic [POS_W-1:0] diff;
	logic             pos_wrap;
	logic [BLK_W-1:0] blk;
	logic [BLK_W-1:0] blk_last;
	logic             off_wrap;
	logic             drop;
	logic             take;
	logic [7:0]       b;

	always_comb begin
		if (cfg.channel_count == '0) begin
			ch = POS_W'(1);
		end else if (POS_W'(cfg.channel_count) > POS_W'(MAX_CHANNELS)) begin
			ch = POS_W'(MAX_CHANNELS);
		end else begin
			ch = POS_W'(cfg.channel_count);
		end
	end

	assign last_chan = CH_W'(ch - POS_W'(1));
	assign diff      = pos_q - ch;
	assign pos_wrap  = {1'b0, pos_q} == ({ch, 1'b0} - (POS_W + 1)'(1));

	assign blk      = (cfg.block_bytes > BLK_W'(MAX_BLOCK_BYTES)) ?
		BLK_W'(MAX_BLOCK_BYTES) : cfg.block_bytes;
	assign blk_last = blk - BLK_W'(1);
	assign off_wrap = BLK_W'(off_q) == blk_last;
	assign drop     = cfg.planar_layout && (cfg.block_bytes < BLK_W'(2));

	assign b          = cfg.keep_order ? data_byte : flip_bits(data_byte);
	assign byte_ready = cmd_ready;
	assign cmd_valid  = byte_valid && !drop;
	assign take       = byte_valid && cmd_ready;

	always_comb begin
		cmd           = '0;
		cmd.data      = b;
		cmd.last_chan = last_chan;
		if (cfg.planar_layout) begin
			cmd.chan = chan_q;
			cmd.pair = off_q[OFF_W-1:1];
			cmd.lane = off_q[0];
			cmd.kind = (chan_q == last_chan && off_q[0]) ? CMD_BURST : CMD_STORE;
		end else if (pos_q < ch) begin
			cmd.kind = CMD_HOLD;
			cmd.chan = pos_q[CH_W-1:0];
		end else begin
			cmd.kind = CMD_PAIR;
			cmd.chan = diff[CH_W-1:0];
			cmd.last = diff[CH_W-1:0] == last_chan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			chan_q <= '0;
			off_q  <= '0;
		end else if (restart) begin
			pos_q  <= '0;
			chan_q <= '0;
			off_q  <= '0;
		end else if (take) begin
			if (drop) begin
				chan_q <= '0;
				off_q  <= '0;
			end else if (cfg.planar_layout) begin
				if (off_wrap) begin
					off_q  <= '0;
					chan_q <= (chan_q == last_chan) ? '0 : chan_q + CH_W'(1);
				end else begin
					off_q <= off_q + OFF_W'(1);
				end
			end else begin
				pos_q <= pos_wrap ? '0 : pos_q + POS_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dop_cmd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dop_cmd_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module dop_cmd_queue import dop_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t push_cmd,
	input  wire logic push_valid,
	output logic      push_ready,
	output cmd_t      pop_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dop_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dop_back
// Executes commands: stores bytes, reads block pairs and forms DoP words.
// ----------------------------------------------------------------------------
module dop_back import dop_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        widen_to_32,
	input  wire cmd_t        cmd,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	output logic             word_valid,
	input  wire logic        word_ready,
	output logic [31:0]      sample_word,
	output logic [2:0]       channel_index,
	output logic             last_of_frame
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_LD   = 2'd2;

	logic [7:0] even_mem [2**ADDR_W];
	logic [7:0] odd_mem  [2**ADDR_W];
	logic [7:0] older_q  [MAX_CHANNELS];

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [CH_W-1:0]   idx_q;
	logic [CH_W-1:0]   idx_d;
	logic [PAIR_W-1:0] pair_q;
	logic [CH_W-1:0]   lastc_q;
	logic [7:0]        even_rd_q;
	logic [7:0]        odd_rd_q;
	logic              marker_odd_q;
	logic              ov_q;
	logic [31:0]       word_q;
	logic [2:0]        chan_out_q;
	logic              last_out_q;

	logic              out_free;
	logic              pop;
	logic              load;
	logic              mem_we;
	logic              older_we;
	logic              rd_en;
	logic              burst_start;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        w_older;
	logic [7:0]        w_newer;
	logic [CH_W-1:0]   w_chan;
	logic              w_last;
	logic [23:0]       w24;

	assign out_free = !ov_q || word_ready;
	assign wr_addr  = {cmd.chan, cmd.pair};
	assign rd_addr  = {idx_q, pair_q};

	always_comb begin
		pop         = 1'b0;
		load        = 1'b0;
		mem_we      = 1'b0;
		older_we    = 1'b0;
		rd_en       = 1'b0;
		burst_start = 1'b0;
		state_d     = state_q;
		idx_d       = idx_q;
		w_older     = even_rd_q;
		w_newer     = odd_rd_q;
		w_chan      = idx_q;
		w_last      = idx_q == lastc_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_HOLD: begin
							pop      = 1'b1;
							older_we = 1'b1;
						end
						CMD_PAIR: begin
							w_older = older_q[cmd.chan];
							w_newer = cmd.data;
							w_chan  = cmd.chan;
							w_last  = cmd.last;
							if (out_free) begin
								pop  = 1'b1;
								load = 1'b1;
							end
						end
						CMD_STORE: begin
							pop    = 1'b1;
							mem_we = 1'b1;
						end
						CMD_BURST: begin
							pop         = 1'b1;
							mem_we      = 1'b1;
							burst_start = 1'b1;
							idx_d       = '0;
							state_d     = ST_RD;
						end
						default: pop = 1'b1;
					endcase
				end
			end
			ST_RD: begin
				rd_en   = 1'b1;
				state_d = ST_LD;
			end
			ST_LD: begin
				if (out_free) begin
					load = 1'b1;
					if (w_last) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + CH_W'(1);
						state_d = ST_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cmd_ready = pop;
	assign w24       = {marker_odd_q ? MARKER_ODD : MARKER_EVEN, w_older, w_newer};

	always_ff @(posedge clk) begin
		if (mem_we && !cmd.lane) begin
			even_mem[wr_addr] <= cmd.data;
		end
		if (rd_en) begin
			even_rd_q <= even_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && cmd.lane) begin
			odd_mem[wr_addr] <= cmd.data;
		end
		if (rd_en) begin
			odd_rd_q <= odd_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (older_we) begin
			older_q[cmd.chan] <= cmd.data;
		end
		if (burst_start) begin
			pair_q  <= cmd.pair;
			lastc_q <= cmd.last_chan;
		end
		if (load) begin
			word_q     <= widen_to_32 ? {w24, 8'h00} : {8'h00, w24};
			chan_out_q <= 3'(w_chan);
			last_out_q <= w_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			marker_odd_q <= 1'b1;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load && w_last) begin
				marker_odd_q <= ~marker_odd_q;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (word_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign word_valid    = ov_q;
	assign sample_word   = word_q;
	assign channel_index = chan_out_q;
	assign last_of_frame = last_out_q;

endmodule
`default_nettype wire

// ----- rtl/dsd_over_pcm_packer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_over_pcm_packer_top
// Packs raw DSD bytes into DoP words, interleaved or planar source layout.
//
//   channel   handshake                     payload
//   bytes     byte_valid / byte_ready       data_byte
//   words     word_valid / word_ready       sample_word, channel_index,
//                                           last_of_frame
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A byte is taken while the two-entry command queue has room.
// Interleaved: the back end retires one byte per cycle unless the output
// stalls, a word per second byte. Planar: each byte is one memory write;
// odd bytes of the last channel start a burst: read, then load, per channel.
// Reset clears position, marker phase and registers; memory holds no reset.
// Output stalls hold the back end; a full queue drops byte_ready.
// ----------------------------------------------------------------------------
module dsd_over_pcm_packer_top import dop_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	output logic             word_valid,
	input  wire logic        word_ready,
	output logic [31:0]      sample_word,
	output logic [2:0]       channel_index,
	output logic             last_of_frame,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t       cfg_q;
	logic       restart;
	logic       wr_en;
	logic [2:0] reg_idx;
	cmd_t       f_cmd;
	logic       f_valid;
	logic       f_ready;
	cmd_t       b_cmd;
	logic       b_valid;
	logic       b_ready;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign restart = wr_en && (reg_idx == REG_CHANNEL_COUNT ||
		reg_idx == REG_PLANAR_LAYOUT || reg_idx == REG_BLOCK_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= CNT_W'(2);
			cfg_q.planar_layout <= 1'b0;
			cfg_q.block_bytes   <= BLK_W'(MAX_BLOCK_BYTES);
			cfg_q.keep_order    <= 1'b1;
			cfg_q.widen_to_32   <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[CNT_W-1:0];
				REG_PLANAR_LAYOUT: cfg_q.planar_layout <= pwdata[0];
				REG_BLOCK_BYTES:   cfg_q.block_bytes   <= pwdata[BLK_W-1:0];
				REG_KEEP_ORDER:    cfg_q.keep_order    <= pwdata[0];
				REG_WIDEN_TO_32:   cfg_q.widen_to_32   <= pwdata[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CHANNEL_COUNT: prdata = 32'(cfg_q.channel_count);
			REG_PLANAR_LAYOUT: prdata = 32'(cfg_q.planar_layout);
			REG_BLOCK_BYTES:   prdata = 32'(cfg_q.block_bytes);
			REG_KEEP_ORDER:    prdata = 32'(cfg_q.keep_order);
			REG_WIDEN_TO_32:   prdata = 32'(cfg_q.widen_to_32);
			default:           prdata = '0;
		endcase
	end

	dop_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.restart    (restart),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.cmd        (f_cmd),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready)
	);

	dop_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (f_cmd),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_cmd    (b_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	dop_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.widen_to_32   (cfg_q.widen_to_32),
		.cmd           (b_cmd),
		.cmd_valid     (b_valid),
		.cmd_ready     (b_ready),
		.word_valid    (word_valid),
		.word_ready    (word_ready),
		.sample_word   (sample_word),
		.channel_index (channel_index),
		.last_of_frame (last_of_frame)
	);

endmodule
`default_nettype wire
